// ===== hw/rtl/sl_pkg.sv =====
// Shared types and constants for the source lexer.
`default_nettype none

package sl_pkg;

    // Token kinds
    localparam logic [2:0] KIND_OP    = 3'd0;
    localparam logic [2:0] KIND_KW    = 3'd1;
    localparam logic [2:0] KIND_STR   = 3'd2;
    localparam logic [2:0] KIND_INT   = 3'd3;
    localparam logic [2:0] KIND_IDENT = 3'd4;

    // Error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_OPEN_STR = 3'd1;
    localparam logic [2:0] ERR_EOF_ESC  = 3'd2;
    localparam logic [2:0] ERR_BAD_ESC  = 3'd3;
    localparam logic [2:0] ERR_LEAD_0   = 3'd4;
    localparam logic [2:0] ERR_UNKNOWN  = 3'd5;

    // Character codes
    localparam logic [20:0] CH_HASH   = 21'h23;
    localparam logic [20:0] CH_V      = 21'h76;
    localparam logic [20:0] CH_A      = 21'h61;
    localparam logic [20:0] CH_R      = 21'h72;
    localparam logic [20:0] CH_QUOTE  = 21'h22;
    localparam logic [20:0] CH_BSLASH = 21'h5C;
    localparam logic [20:0] CH_NL     = 21'h0A;
    localparam logic [20:0] CH_0      = 21'h30;
    localparam logic [20:0] CH_9      = 21'h39;

    localparam logic [31:0] LEN_MAX = 32'hFFFF_FFFF;

    // Result queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    typedef struct packed {
        logic sp;       // whitespace
        logic nl;       // line feed
        logic hash;
        logic op;
        logic quote;
        logic bslash;
        logic dig;
        logic zero;
        logic idf;      // may start an identifier
        logic idn;      // may continue an identifier
        logic esc_ok;   // legal after a backslash
        logic ch_v;
        logic ch_a;
        logic ch_r;
    } t_char_class;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  err;
        logic [31:0] start;
        logic [31:0] len;
        logic [31:0] line;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [1:0] n;      // results pushed this cycle, 0 to 2
        t_result    r0;
        t_result    r1;
    } t_push;

endpackage

`default_nettype wire

// ===== hw/rtl/sl_class.sv =====
// Character classifier for the source lexer.
`default_nettype none

module sl_class import sl_pkg::*; (
    input  wire logic [20:0] i_code_point,
    output t_char_class      o_class
);

    logic w_sp;
    logic w_op;
    logic w_letter;
    logic w_high_ok;

    always_comb begin
        case (i_code_point) inside
            [21'h09:21'h0D], 21'h20, 21'h85, 21'hA0, 21'h1680,
            [21'h2000:21'h200A], 21'h2028, 21'h2029, 21'h202F,
            21'h205F, 21'h3000: w_sp = 1'b1;
            default:            w_sp = 1'b0;
        endcase
    end

    // { } [ ] ( ) = ; . : ` + - * / < >
    always_comb begin
        case (i_code_point) inside
            21'h7B, 21'h7D, 21'h5B, 21'h5D, 21'h28, 21'h29, 21'h3D,
            21'h3B, 21'h2E, 21'h3A, 21'h60, 21'h2B, 21'h2D, 21'h2A,
            21'h2F, 21'h3C, 21'h3E: w_op = 1'b1;
            default:                w_op = 1'b0;
        endcase
    end

    always_comb begin
        case (i_code_point) inside
            [21'h41:21'h5A], [21'h61:21'h7A], 21'h5F: w_letter = 1'b1;
            default:                                  w_letter = 1'b0;
        endcase
    end

    // Non-ASCII identifier characters: in range, no surrogate, no space
    assign w_high_ok = (i_code_point >= 21'h80) && (i_code_point <= 21'h10FFFF)
                       && !((i_code_point >= 21'hD800) && (i_code_point <= 21'hDFFF))
                       && !w_sp;

    always_comb begin
        o_class.sp     = w_sp;
        o_class.nl     = (i_code_point == CH_NL);
        o_class.hash   = (i_code_point == CH_HASH);
        o_class.op     = w_op;
        o_class.quote  = (i_code_point == CH_QUOTE);
        o_class.bslash = (i_code_point == CH_BSLASH);
        o_class.dig    = (i_code_point >= CH_0) && (i_code_point <= CH_9);
        o_class.zero   = (i_code_point == CH_0);
        o_class.idf    = w_letter || w_high_ok;
        o_class.idn    = w_letter || w_high_ok || o_class.dig;
        o_class.esc_ok = (i_code_point == 21'h6E) || (i_code_point == 21'h74)
                         || (i_code_point == CH_BSLASH) || (i_code_point == CH_QUOTE);
        o_class.ch_v   = (i_code_point == CH_V);
        o_class.ch_a   = (i_code_point == CH_A);
        o_class.ch_r   = (i_code_point == CH_R);
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sl_core.sv =====
// Input register, lexer state and one-step transition logic.
`default_nettype none

module sl_core import sl_pkg::*; #(
    parameter int POS_BITS  = 32,
    parameter int LINE_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [20:0] i_code_point,
    input  wire logic        i_has_char,
    input  wire logic        i_end_of_file,
    input  wire logic        i_room,
    output t_push            o_push
);

    typedef enum logic [2:0] {
        M_IDLE, M_COMMENT, M_IDENT, M_INT, M_STR, M_ESC, M_ERR
    } t_mode;

    localparam logic [1:0] KWP_NONE = 2'd0;
    localparam logic [1:0] KWP_V    = 2'd1;
    localparam logic [1:0] KWP_VA   = 2'd2;
    localparam logic [1:0] KWP_VAR  = 2'd3;

    localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

    function automatic t_result mk(input logic [2:0] kind, input logic [2:0] err,
                                   input logic [31:0] start, input logic [31:0] len,
                                   input logic [31:0] line);
        t_result r;
        r.kind  = kind;
        r.err   = err;
        r.start = start;
        r.len   = len;
        r.line  = line;
        r.last  = 1'b0;
        return r;
    endfunction

    // Input register
    logic        r_in_v;
    logic [20:0] r_cp;
    logic        r_has;
    logic        r_eof;

    // Lexer state
    t_mode                 r_mode, n_mode;
    logic [POS_BITS-1:0]   r_start, n_start;
    logic [31:0]           r_len, n_len;
    logic [LINE_BITS-1:0]  r_line, n_line;
    logic [POS_BITS-1:0]   r_pos, n_pos;
    logic [1:0]            r_kwp, n_kwp;
    logic                  r_lz, n_lz;

    t_char_class w_cls;
    logic        w_go;
    logic        do_idle;
    logic [31:0] len_inc;
    logic [31:0] pos32;
    logic [31:0] line32;
    logic        end_v, idle_v, eof_v;
    t_result     end_r, idle_r, eof_r;
    logic [1:0]  cnt;

    sl_class u_class (
        .i_code_point (r_cp),
        .o_class      (w_cls)
    );

    assign w_go    = r_in_v && i_room;
    assign o_ready = !r_in_v || i_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (o_ready) begin
            r_in_v <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_cp  <= i_code_point;
            r_has <= i_has_char;
            r_eof <= i_end_of_file;
        end
    end

    assign len_inc = (r_len == LEN_MAX) ? r_len : r_len + 32'd1;
    assign pos32   = 32'(r_pos);
    assign line32  = 32'(r_line);

    always_comb begin
        n_mode  = r_mode;
        n_start = r_start;
        n_len   = r_len;
        n_line  = r_line;
        n_pos   = r_pos;
        n_kwp   = r_kwp;
        n_lz    = r_lz;
        do_idle = 1'b0;
        end_v   = 1'b0;
        idle_v  = 1'b0;
        eof_v   = 1'b0;
        end_r   = '0;
        idle_r  = '0;
        eof_r   = '0;

        // Continue or finish the token in progress
        if (r_has) begin
            unique case (r_mode)
                M_IDLE: begin
                    do_idle = 1'b1;
                end
                M_COMMENT: begin
                    if (w_cls.nl) begin
                        n_mode  = M_IDLE;
                        do_idle = 1'b1;
                    end
                end
                M_IDENT: begin
                    if (w_cls.idn) begin
                        n_len = len_inc;
                        if (r_kwp == KWP_V && w_cls.ch_a) begin
                            n_kwp = KWP_VA;
                        end else if (r_kwp == KWP_VA && w_cls.ch_r) begin
                            n_kwp = KWP_VAR;
                        end else begin
                            n_kwp = KWP_NONE;
                        end
                    end else begin
                        end_v   = 1'b1;
                        end_r   = mk((r_kwp == KWP_VAR) ? KIND_KW : KIND_IDENT, ERR_NONE,
                                     32'(r_start), r_len, line32);
                        n_mode  = M_IDLE;
                        do_idle = 1'b1;
                    end
                end
                M_INT: begin
                    if (w_cls.dig) begin
                        n_len = len_inc;
                    end else if (r_lz && r_len > 32'd1) begin
                        end_v  = 1'b1;
                        end_r  = mk(KIND_OP, ERR_LEAD_0, 32'(r_start), 32'd0, line32);
                        n_mode = M_ERR;
                    end else begin
                        end_v   = 1'b1;
                        end_r   = mk(KIND_INT, ERR_NONE, 32'(r_start), r_len, line32);
                        n_mode  = M_IDLE;
                        do_idle = 1'b1;
                    end
                end
                M_STR: begin
                    if (w_cls.nl) begin
                        end_v  = 1'b1;
                        end_r  = mk(KIND_OP, ERR_OPEN_STR, 32'(r_start), 32'd0, line32);
                        n_mode = M_ERR;
                    end else begin
                        n_len = len_inc;
                        if (w_cls.quote) begin
                            end_v  = 1'b1;
                            end_r  = mk(KIND_STR, ERR_NONE, 32'(r_start), len_inc, line32);
                            n_mode = M_IDLE;
                        end else if (w_cls.bslash) begin
                            n_mode = M_ESC;
                        end
                    end
                end
                M_ESC: begin
                    if (w_cls.esc_ok) begin
                        n_len  = len_inc;
                        n_mode = M_STR;
                    end else begin
                        end_v  = 1'b1;
                        end_r  = mk(KIND_OP, ERR_BAD_ESC, 32'(r_start), 32'd0, line32);
                        n_mode = M_ERR;
                    end
                end
                M_ERR: begin
                end
                default: begin
                end
            endcase
        end

        // Lex the character from the idle mode
        if (r_has && do_idle) begin
            if (w_cls.sp) begin
                if (w_cls.nl && r_line != LINE_MAX) begin
                    n_line = r_line + LINE_BITS'(1);
                end
            end else if (w_cls.hash) begin
                n_mode = M_COMMENT;
            end else if (w_cls.op) begin
                idle_v = 1'b1;
                idle_r = mk(KIND_OP, ERR_NONE, pos32, 32'd1, line32);
            end else if (w_cls.quote) begin
                n_start = r_pos;
                n_len   = 32'd1;
                n_mode  = M_STR;
            end else if (w_cls.dig) begin
                n_start = r_pos;
                n_len   = 32'd1;
                n_lz    = w_cls.zero;
                n_mode  = M_INT;
            end else if (w_cls.idf) begin
                n_start = r_pos;
                n_len   = 32'd1;
                n_kwp   = w_cls.ch_v ? KWP_V : KWP_NONE;
                n_mode  = M_IDENT;
            end else begin
                idle_v = 1'b1;
                idle_r = mk(KIND_OP, ERR_UNKNOWN, pos32, 32'd0, line32);
                n_mode = M_ERR;
            end
        end

        if (r_has) begin
            n_pos = r_pos + POS_BITS'(1);
        end

        // Close whatever is open at end of file, then return to reset values
        if (r_eof) begin
            unique case (n_mode)
                M_IDENT: begin
                    eof_v = 1'b1;
                    eof_r = mk(KIND_IDENT, ERR_NONE, 32'(n_start), n_len, line32);
                end
                M_INT: begin
                    eof_v = 1'b1;
                    if (n_lz && n_len > 32'd1) begin
                        eof_r = mk(KIND_OP, ERR_LEAD_0, 32'(n_start), 32'd0, line32);
                    end else begin
                        eof_r = mk(KIND_INT, ERR_NONE, 32'(n_start), n_len, line32);
                    end
                end
                M_STR: begin
                    eof_v = 1'b1;
                    eof_r = mk(KIND_OP, ERR_OPEN_STR, 32'(n_start), 32'd0, line32);
                end
                M_ESC: begin
                    eof_v = 1'b1;
                    eof_r = mk(KIND_OP, ERR_EOF_ESC, 32'(n_start), 32'd0, line32);
                end
                M_IDLE, M_COMMENT, M_ERR: begin
                end
                default: begin
                end
            endcase
            n_mode  = M_IDLE;
            n_start = '0;
            n_len   = '0;
            n_line  = LINE_BITS'(1);
            n_pos   = '0;
            n_kwp   = KWP_NONE;
            n_lz    = 1'b0;
        end
    end

    // Pack up to two results in order
    assign cnt = 2'(end_v) + 2'(idle_v) + 2'(eof_v);

    always_comb begin
        o_push.n  = w_go ? cnt : 2'd0;
        o_push.r0 = end_v ? end_r : (idle_v ? idle_r : eof_r);
        o_push.r1 = end_v ? (idle_v ? idle_r : eof_r) : eof_r;
        o_push.r0.last = (cnt == 2'd1);
        o_push.r1.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_start <= '0;
            r_len   <= '0;
            r_line  <= LINE_BITS'(1);
            r_pos   <= '0;
            r_kwp   <= KWP_NONE;
            r_lz    <= 1'b0;
        end else if (w_go) begin
            r_mode  <= n_mode;
            r_start <= n_start;
            r_len   <= n_len;
            r_line  <= n_line;
            r_pos   <= n_pos;
            r_kwp   <= n_kwp;
            r_lz    <= n_lz;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sl_outq.sv =====
// Small result queue: takes up to two results per cycle, gives one.
`default_nettype none

module sl_outq import sl_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_push i_push,
    output logic       o_room,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_result    o_head
);

    t_result         r_slot [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_AW:0]   r_cnt;
    logic            w_pop;

    assign o_valid = (r_cnt != '0);
    assign o_head  = r_slot[r_rp];
    assign w_pop   = o_valid && i_ready;
    // Leave space for a two-result request
    assign o_room  = (r_cnt <= (Q_AW+1)'(Q_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_slot[r_wp] <= i_push.r0;
        end
        if (i_push.n == 2'd2) begin
            r_slot[r_wp + Q_AW'(1)] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + Q_AW'(i_push.n);
            r_rp  <= r_rp + Q_AW'(w_pop);
            r_cnt <= r_cnt + (Q_AW+1)'(i_push.n) - (Q_AW+1)'(w_pop);
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/source_lexer.sv =====
// Streaming source lexer: one code point per request, tokens out.
// A request is held in the input register, and its results are registered in the result queue.
// Throughput: one request per cycle while the consumer is ready and each request gives
// at most one result; two-result requests are paced by the single-result output port.
// Reset: synchronous, active low; mode idle, line 1, offsets zero, queue empty.
// After an end-of-file request the lexer returns to the reset state by itself.
`default_nettype none

module source_lexer import sl_pkg::*; #(
    parameter int POS_BITS  = 32,
    parameter int LINE_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [20:0] i_code_point,
    input  wire logic        i_has_char,
    input  wire logic        i_end_of_file,
    // result channel
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_token_kind,
    output logic [2:0]       o_error_code,
    output logic [31:0]      o_start_offset,
    output logic [31:0]      o_token_length,
    output logic [31:0]      o_line_number,
    output logic             o_last_of_run
);

    t_push   w_push;
    logic    w_room;
    t_result w_head;

    // Register the request, classify it and step the lexer state. A request
    // moves out of the input register only when the queue can take two results,
    // so a token end followed by a new result never overruns.
    sl_core #(
        .POS_BITS  (POS_BITS),
        .LINE_BITS (LINE_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_code_point  (i_code_point),
        .i_has_char    (i_has_char),
        .i_end_of_file (i_end_of_file),
        .i_room        (w_room),
        .o_push        (w_push)
    );

    // Hold results until the consumer takes them; keeps the request side moving
    // while a finished result waits.
    sl_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_head  (w_head)
    );

    assign o_token_kind   = w_head.kind;
    assign o_error_code   = w_head.err;
    assign o_start_offset = w_head.start;
    assign o_token_length = w_head.len;
    assign o_line_number  = w_head.line;
    assign o_last_of_run  = w_head.last;

endmodule

`default_nettype wire

// ===== hw/rtl/source_lexer_chk.sv =====
// Port-level checker for the source lexer, bound to the top level.
`default_nettype none

module source_lexer_chk import sl_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [2:0]  o_token_kind,
    input wire logic [2:0]  o_error_code,
    input wire logic [31:0] o_start_offset,
    input wire logic [31:0] o_token_length,
    input wire logic [31:0] o_line_number,
    input wire logic        o_last_of_run
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable({o_token_kind, o_error_code,
            o_start_offset, o_token_length, o_line_number, o_last_of_run}))
        else $error("result changed while stalled");

    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error_code != ERR_NONE |->
            o_token_kind == KIND_OP && o_token_length == 32'd0)
        else $error("error result carries a token");

    a_op_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error_code == ERR_NONE && o_token_kind == KIND_OP |->
            o_token_length == 32'd1)
        else $error("operator length not one");

    a_kw_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_token_kind == KIND_KW |-> o_token_length == 32'd3)
        else $error("keyword length not three");

    a_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_line_number != 32'd0)
        else $error("line number zero");

endmodule

bind source_lexer source_lexer_chk u_chk (.*);

`default_nettype wire
